// ===== hw/rtl/eerp_pkg.sv =====
package eerp_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int ACT_W       = 2;
    localparam int IDX_W       = 6;
    localparam int OCC_W       = 8;
    localparam int CNT_W       = 7;
    localparam int RND_W       = 15;
    localparam int TDATA_W     = 72;
    localparam int TUSER_W     = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FORCE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONCE_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd4;

    // dividend source for the remainder unit
    localparam logic [1:0] MOD_RF    = 2'd0;
    localparam logic [1:0] MOD_RS    = 2'd1;
    localparam logic [1:0] MOD_CURP1 = 2'd2;

    // walk start position
    localparam logic [1:0] START_ZERO = 2'd0;
    localparam logic [1:0] START_CUR  = 2'd1;
    localparam logic [1:0] START_REM  = 2'd2;

    // walk length
    localparam logic LEN_FULL = 1'b0;
    localparam logic LEN_SEQ  = 1'b1;

    typedef struct packed {
        logic             queue_enable;
        logic             once_mode;
        logic             random_mode;
        logic             ignore_count;
        logic [CNT_W-1:0] entry_count;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [OCC_W-1:0] min_players;
        logic [OCC_W-1:0] max_players;
        logic             current_known;
        logic [IDX_W-1:0] current_index;
        logic [OCC_W-1:0] player_count;
        logic [RND_W-1:0] random_first;
        logic [RND_W-1:0] random_second;
    } item_t;

    typedef struct packed {
        logic       load_item;
        logic       wr_entry;
        logic       force_set;
        logic       zero_cur;
        logic       take_forced;
        logic       prep;
        logic       mod_start;
        logic [1:0] mod_src;
        logic       walk_init;
        logic [1:0] start_sel;
        logic       len_sel;
        logic       cur_from_rem;
        logic       skip;
        logic       walk_step;
        logic       clear_marks;
        logic       take_hit;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic forced_pending;
        logic cur_ge_cnt;
        logic mod_done;
        logic hit;
        logic walk_over;
        logic out_busy;
    } sts_t;

    function automatic logic fits(
        input logic [OCC_W-1:0] lo,
        input logic [OCC_W-1:0] hi,
        input logic [OCC_W-1:0] p,
        input logic             ign
    );
        logic in_range;
        in_range = (lo <= p) && (hi >= p);
        return in_range || (lo == '0) || ((p == '0) && (lo == OCC_W'(1))) || ign;
    endfunction

endpackage

// ===== hw/rtl/eerp_mod.sv =====
module eerp_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [eerp_pkg::RND_W-1:0]    dividend,
    input  logic [eerp_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [eerp_pkg::CNT_W-1:0]    remainder
);

    localparam int DW   = eerp_pkg::RND_W;
    localparam int CW   = eerp_pkg::CNT_W;
    localparam int STEP_W = $clog2(DW + 1);

    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW:0]       trial;

    // one quotient bit a cycle, keep only the remainder
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DW-1]};
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = CW'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = CW'(trial);
            end
            dvd_next  = {dvd_reg[DW-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/eerp_ctrl.sv =====
module eerp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eerp_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    input  logic [eerp_pkg::ACT_W-1:0]  action,
    output logic                        in_ready,
    input  eerp_pkg::sts_t              sts,
    output eerp_pkg::cmd_t              cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_MOD1   = 4'd3;
    localparam logic [3:0] S_WALK1  = 4'd4;
    localparam logic [3:0] S_FAIL   = 4'd5;
    localparam logic [3:0] S_MOD2   = 4'd6;
    localparam logic [3:0] S_WALK2  = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       seq;

    assign seq      = !cfg.once_mode && !cfg.random_mode;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (action)
                        eerp_pkg::ACT_WRITE: cmd.wr_entry = 1'b1;
                        eerp_pkg::ACT_FORCE: cmd.force_set = 1'b1;
                        eerp_pkg::ACT_PICK:
                        begin
                            if (cfg.queue_enable)
                            begin
                                state_next = S_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_START:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.zero_cur = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.forced_pending)
                begin
                    cmd.take_forced = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (cfg.random_mode || seq)
                begin
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = cfg.random_mode ? eerp_pkg::MOD_RF : eerp_pkg::MOD_CURP1;
                    state_next    = S_MOD1;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    cmd.start_sel = sts.cur_ge_cnt ? eerp_pkg::START_ZERO : eerp_pkg::START_CUR;
                    cmd.len_sel   = eerp_pkg::LEN_FULL;
                    cmd.skip      = 1'b1;
                    state_next    = S_WALK1;
                end
            end
            S_MOD1:
            begin
                if (sts.mod_done)
                begin
                    cmd.walk_init    = 1'b1;
                    cmd.start_sel    = eerp_pkg::START_REM;
                    cmd.cur_from_rem = cfg.random_mode;
                    cmd.len_sel      = (cfg.random_mode || sts.cur_ge_cnt) ?
                                       eerp_pkg::LEN_FULL : eerp_pkg::LEN_SEQ;
                    cmd.skip         = 1'b1;
                    state_next       = S_WALK1;
                end
            end
            S_WALK1:
            begin
                cmd.walk_step = 1'b1;
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (sts.walk_over)
                begin
                    state_next = S_FAIL;
                end
            end
            S_FAIL:
            begin
                // nothing unvisited fits: forget the marks, sweep again
                cmd.clear_marks = cfg.once_mode;
                if (cfg.random_mode)
                begin
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = eerp_pkg::MOD_RS;
                    state_next    = S_MOD2;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    cmd.start_sel = eerp_pkg::START_ZERO;
                    cmd.len_sel   = eerp_pkg::LEN_FULL;
                    state_next    = S_WALK2;
                end
            end
            S_MOD2:
            begin
                if (sts.mod_done)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.start_sel = eerp_pkg::START_REM;
                    cmd.len_sel   = eerp_pkg::LEN_FULL;
                    state_next    = S_WALK2;
                end
            end
            S_WALK2:
            begin
                cmd.walk_step = 1'b1;
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (sts.walk_over)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/eerp_dp.sv =====
module eerp_dp #(
    parameter int MAX_ENTRIES = eerp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  eerp_pkg::cfg_t                    cfg,
    input  eerp_pkg::cmd_t                    cmd,
    input  eerp_pkg::item_t                   item,
    output eerp_pkg::sts_t                    sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [eerp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = eerp_pkg::CNT_W;
    localparam int IW     = eerp_pkg::IDX_W;
    localparam int OW     = eerp_pkg::OCC_W;
    localparam int RW     = eerp_pkg::RND_W;

    logic [OW-1:0] min_mem [MAX_ENTRIES];
    logic [OW-1:0] max_mem [MAX_ENTRIES];
    logic [OW-1:0] rd_min_reg;
    logic [OW-1:0] rd_max_reg;

    eerp_pkg::item_t   item_reg;
    logic [MAX_ENTRIES-1:0] vis_reg;
    logic [IW-1:0]     current_slot_reg;
    logic              forced_pending_reg;
    logic [IW-1:0]     forced_slot_reg;
    logic [CW-1:0]     cur_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     left_reg;
    logic [CW-1:0]     eval_pos_reg;
    logic              eval_v_reg;
    logic              skip_reg;
    logic              out_valid_reg;
    logic [IW-1:0]     out_reg;

    logic [CW-1:0]     cnt;
    logic              wr_ok;
    logic              ci_ok;
    logic [RW-1:0]     mod_dvd;
    logic              mod_done;
    logic [CW-1:0]     mod_rem;
    logic [CW-1:0]     pos_inc;
    logic [CW-1:0]     init_pos;
    logic [CW-1:0]     init_len;
    logic              fit;
    logic              hit;

    assign cnt   = cfg.entry_count;
    assign wr_ok = int'(item.entry_index) < MAX_ENTRIES;
    assign ci_ok = item_reg.current_known && ({1'b0, item_reg.current_index} < cnt);

    always_comb
    begin
        case (cmd.mod_src)
            eerp_pkg::MOD_RF:    mod_dvd = item_reg.random_first;
            eerp_pkg::MOD_RS:    mod_dvd = item_reg.random_second;
            eerp_pkg::MOD_CURP1: mod_dvd = RW'(cur_reg) + RW'(1);
            default:             mod_dvd = item_reg.random_first;
        endcase
    end

    eerp_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (mod_dvd),
        .divisor   (cnt),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        case (cmd.start_sel)
            eerp_pkg::START_ZERO: init_pos = '0;
            eerp_pkg::START_CUR:  init_pos = cur_reg;
            eerp_pkg::START_REM:  init_pos = mod_rem;
            default:              init_pos = '0;
        endcase
        if (cmd.len_sel == eerp_pkg::LEN_SEQ && cnt > CW'(1))
        begin
            init_len = cnt - CW'(1);
        end
        else if (cmd.len_sel == eerp_pkg::LEN_SEQ)
        begin
            init_len = CW'(1);
        end
        else
        begin
            init_len = cnt;
        end
    end

    // wrap the walk position at the entry count
    assign pos_inc = (CW'(pos_reg + CW'(1)) == cnt) ? '0 : CW'(pos_reg + CW'(1));

    assign fit = eerp_pkg::fits(rd_min_reg, rd_max_reg, item_reg.player_count,
                                cfg.ignore_count);
    assign hit = eval_v_reg && fit && !(skip_reg && vis_reg[SLOT_W'(eval_pos_reg)]);

    // entry table, read data registered in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry && wr_ok)
        begin
            min_mem[SLOT_W'(item.entry_index)] <= item.min_players;
            max_mem[SLOT_W'(item.entry_index)] <= item.max_players;
        end
        rd_min_reg <= min_mem[SLOT_W'(pos_reg)];
        rd_max_reg <= max_mem[SLOT_W'(pos_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.finish)
        begin
            out_reg <= cur_reg[IW-1:0];
        end
        if (cmd.walk_step)
        begin
            eval_pos_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_reg            <= '0;
            current_slot_reg   <= '0;
            forced_pending_reg <= 1'b0;
            forced_slot_reg    <= '0;
            cur_reg            <= '0;
            pos_reg            <= '0;
            left_reg           <= '0;
            eval_v_reg         <= 1'b0;
            skip_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.wr_entry && wr_ok)
            begin
                vis_reg[SLOT_W'(item.entry_index)] <= 1'b0;
            end
            if (cmd.force_set && ({1'b0, item.entry_index} < cnt))
            begin
                forced_slot_reg    <= item.entry_index;
                forced_pending_reg <= 1'b1;
            end
            if (cmd.zero_cur)
            begin
                current_slot_reg <= '0;
            end
            if (cmd.take_forced)
            begin
                cur_reg            <= {1'b0, forced_slot_reg};
                forced_pending_reg <= 1'b0;
            end
            if (cmd.prep)
            begin
                cur_reg <= ci_ok ? {1'b0, item_reg.current_index} : {1'b0, current_slot_reg};
                if (!cfg.once_mode)
                begin
                    vis_reg <= '0;
                end
                else if (ci_ok)
                begin
                    vis_reg[SLOT_W'(item_reg.current_index)] <= 1'b1;
                end
            end
            if (cmd.clear_marks)
            begin
                vis_reg <= '0;
            end
            if (cmd.walk_init)
            begin
                pos_reg    <= init_pos;
                left_reg   <= init_len;
                eval_v_reg <= 1'b0;
                skip_reg   <= cmd.skip;
                if (cmd.cur_from_rem)
                begin
                    cur_reg <= mod_rem;
                end
            end
            if (cmd.walk_step)
            begin
                if (left_reg != '0)
                begin
                    eval_v_reg <= 1'b1;
                    pos_reg    <= pos_inc;
                    left_reg   <= left_reg - CW'(1);
                end
                else
                begin
                    eval_v_reg <= 1'b0;
                end
            end
            if (cmd.take_hit)
            begin
                cur_reg <= eval_pos_reg;
            end
            if (cmd.finish)
            begin
                current_slot_reg <= cur_reg[IW-1:0];
                out_valid_reg    <= 1'b1;
                if (cfg.once_mode)
                begin
                    vis_reg[SLOT_W'(cur_reg[IW-1:0])] <= 1'b1;
                end
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.cnt_zero       = (cnt == '0);
    assign sts.forced_pending = forced_pending_reg;
    assign sts.cur_ge_cnt     = (cur_reg >= cnt);
    assign sts.mod_done       = mod_done;
    assign sts.hit            = hit;
    assign sts.walk_over      = (left_reg == '0) && !eval_v_reg;
    assign sts.out_busy       = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(eerp_pkg::OUT_TDATA_W - IW){1'b0}}, out_reg};

endmodule

// ===== hw/rtl/eligible_entry_rotation_picker.sv =====
// Table write and force words: a new word may follow every cycle while no pick is in progress.
// Pick: a pending forced slot is taken straight away; a full search takes up to
// two table sweeps at one entry a cycle through the single read port, plus a
// bit-serial remainder before each sweep in random mode (before the first in sequential mode).
// Reset: registers to their defaults, visited marks cleared, table contents undefined.
module eligible_entry_rotation_picker #(
    parameter int MAX_ENTRIES = eerp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index, min_players, max_players, current_known, current_index,
    // player_count, random_first, random_second, zero fill
    input  logic [eerp_pkg::TDATA_W-1:0]        s_tdata,
    // action
    input  logic [eerp_pkg::TUSER_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chosen_index, zero fill
    output logic [eerp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [eerp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eerp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW    = eerp_pkg::CNT_W;
    localparam int CAP_I = (MAX_ENTRIES < (1 << CW) - 1) ? MAX_ENTRIES : (1 << CW) - 1;
    localparam logic [CW-1:0] CAP = CW'(CAP_I);

    eerp_pkg::cfg_t  cfg_reg;
    eerp_pkg::item_t item;
    eerp_pkg::cmd_t  cmd;
    eerp_pkg::sts_t  sts;

    assign cfg_ready = 1'b1;

    // hold the entry count capped at the table depth (and at 127)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.queue_enable <= 1'b1;
            cfg_reg.once_mode    <= 1'b1;
            cfg_reg.random_mode  <= 1'b1;
            cfg_reg.ignore_count <= 1'b0;
            cfg_reg.entry_count  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                eerp_pkg::REG_QUEUE_ENABLE: cfg_reg.queue_enable <= cfg_data[0];
                eerp_pkg::REG_ONCE_MODE:    cfg_reg.once_mode    <= cfg_data[0];
                eerp_pkg::REG_RANDOM_MODE:  cfg_reg.random_mode  <= cfg_data[0];
                eerp_pkg::REG_IGNORE_COUNT: cfg_reg.ignore_count <= cfg_data[0];
                eerp_pkg::REG_ENTRY_COUNT:
                begin
                    cfg_reg.entry_count <= (CW'(cfg_data) > CAP) ? CAP : CW'(cfg_data);
                end
                default: ;
            endcase
        end
    end

    assign item.entry_index   = s_tdata[5:0];
    assign item.min_players   = s_tdata[13:6];
    assign item.max_players   = s_tdata[21:14];
    assign item.current_known = s_tdata[22];
    assign item.current_index = s_tdata[28:23];
    assign item.player_count  = s_tdata[36:29];
    assign item.random_first  = s_tdata[51:37];
    assign item.random_second = s_tdata[66:52];

    eerp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .action   (s_tuser[eerp_pkg::ACT_W-1:0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eerp_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .item     (item),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
